// File: src/safs_pkg.sv
// Shared types, register indexes and constants for the screen-aware frequency stepper.
package safs_pkg;

    localparam int FreqW = 22;   // frequency fields in kHz
    localparam int PctW  = 7;    // percent fields
    localparam int ProdW = FreqW + PctW;       // percent times frequency
    localparam int StepW = FreqW + 1;          // percent times freq / 100 fits here
    localparam int SumW  = FreqW + 2;          // room for a doubled step or a sum

    // floor(2^29 / 100); product estimate is at most one below the true quotient
    localparam int RecipShift = ProdW;
    localparam int RecipW     = 23;
    localparam logic [RecipW-1:0] RECIP_100 = RecipW'(5368709);
    localparam logic [7:0] PCT_DIV = 8'd100;

    localparam int AddrW = 5;
    localparam int DataW = 32;

    // Register index taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_UP_THRESHOLD   = 3'd0,
        REG_DOWN_THRESHOLD = 3'd1,
        REG_STEP_PERCENT   = 3'd2,
        REG_SLEEP_CAP      = 3'd3,
        REG_FREQ_MAX       = 3'd4,
        REG_FREQ_MIN       = 3'd5
    } reg_idx_t;

    localparam logic [PctW-1:0]  UP_THRESHOLD_RST   = 7'd65;
    localparam logic [PctW-1:0]  DOWN_THRESHOLD_RST = 7'd35;
    localparam logic [PctW-1:0]  STEP_PERCENT_RST   = 7'd10;
    localparam logic [PctW-1:0]  SLEEP_CAP_RST      = 7'd33;
    localparam logic [FreqW-1:0] FREQ_MAX_RST       = {FreqW{1'b1}};
    localparam logic [FreqW-1:0] FREQ_MIN_RST       = '0;

    // Cycles the input is held off while the derived step and cap settle
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef struct packed {
        logic [PctW-1:0]  load_pct;
        logic [FreqW-1:0] current_freq;
        logic             screen_on;
    } sample_t;

    typedef struct packed {
        logic             issue;
        logic [FreqW-1:0] target_freq;
        logic             round_mode;
    } result_t;

endpackage

// File: src/screen_aware_freq_stepper_core.sv
// Top level of the screen-aware frequency stepper: config, derived limits and sample path.
// A sample goes through the input register and then the result register to m_tdata.
// Throughput: one sample per cycle unless m_tready stalls; the next sample may enter while a
// result waits to be taken. After reset, and after every configuration write, s_tready stays
// low while the step and sleep-cap values (percent of freq_max, divided by 100) are recomputed.
// Reset (aresetn low, synchronous) loads the register defaults and clears last_request to 0.
module screen_aware_freq_stepper_core
    import safs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Sample stream. tdata: load_pct[6:0], current_freq[28:7], screen_on[29], zero[31:30]
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    // Result stream. tdata: issue[0], target_freq[22:1], round_mode[23]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [DataW-1:0]    pwdata,
    output logic [DataW-1:0]    prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PctW-1:0]  up_th_reg, dn_th_reg, step_pct_reg, cap_pct_reg;
    logic [FreqW-1:0] fmax_reg, fmin_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_th_reg    <= UP_THRESHOLD_RST;
            dn_th_reg    <= DOWN_THRESHOLD_RST;
            step_pct_reg <= STEP_PERCENT_RST;
            cap_pct_reg  <= SLEEP_CAP_RST;
            fmax_reg     <= FREQ_MAX_RST;
            fmin_reg     <= FREQ_MIN_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_UP_THRESHOLD:   up_th_reg    <= pwdata[PctW-1:0];
                REG_DOWN_THRESHOLD: dn_th_reg    <= pwdata[PctW-1:0];
                REG_STEP_PERCENT:   step_pct_reg <= pwdata[PctW-1:0];
                REG_SLEEP_CAP:      cap_pct_reg  <= pwdata[PctW-1:0];
                REG_FREQ_MAX:       fmax_reg     <= pwdata[FreqW-1:0];
                REG_FREQ_MIN:       fmin_reg     <= pwdata[FreqW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_UP_THRESHOLD:   prdata = DataW'(up_th_reg);
            REG_DOWN_THRESHOLD: prdata = DataW'(dn_th_reg);
            REG_STEP_PERCENT:   prdata = DataW'(step_pct_reg);
            REG_SLEEP_CAP:      prdata = DataW'(cap_pct_reg);
            REG_FREQ_MAX:       prdata = DataW'(fmax_reg);
            REG_FREQ_MIN:       prdata = DataW'(fmin_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Derived limits: step = step_pct * fmax / 100, cap = cap_pct * fmax / 100.
    // Three free-running stages: product, reciprocal estimate, correction.
    // The estimate floor(x * floor(2^29/100) / 2^29) is never more than one
    // below the true quotient for x < 2^29, so one compare fixes it.
    // ------------------------------------------------------------------
    logic [ProdW-1:0]        step_prod_reg, cap_prod_reg;
    logic [ProdW-1:0]        step_x_reg, cap_x_reg;
    logic [StepW-1:0]        step_q0_reg, cap_q0_reg;
    logic [StepW-1:0]        step_reg, cap_reg;
    logic [ProdW+RecipW-1:0] step_est, cap_est;
    logic [ProdW-1:0]        step_rem, cap_rem;
    logic [1:0]              settle_reg;

    assign step_est = (ProdW+RecipW)'(step_prod_reg) * (ProdW+RecipW)'(RECIP_100);
    assign cap_est  = (ProdW+RecipW)'(cap_prod_reg) * (ProdW+RecipW)'(RECIP_100);
    assign step_rem = step_x_reg - ProdW'(step_q0_reg) * ProdW'(PCT_DIV);
    assign cap_rem  = cap_x_reg - ProdW'(cap_q0_reg) * ProdW'(PCT_DIV);

    always_ff @(posedge aclk) begin
        step_prod_reg <= ProdW'(step_pct_reg) * ProdW'(fmax_reg);
        cap_prod_reg  <= ProdW'(cap_pct_reg) * ProdW'(fmax_reg);
        step_x_reg    <= step_prod_reg;
        cap_x_reg     <= cap_prod_reg;
        step_q0_reg   <= step_est[RecipShift +: StepW];
        cap_q0_reg    <= cap_est[RecipShift +: StepW];
        step_reg      <= (step_rem >= ProdW'(PCT_DIV)) ? step_q0_reg + 1'b1 : step_q0_reg;
        cap_reg       <= (cap_rem >= ProdW'(PCT_DIV)) ? cap_q0_reg + 1'b1 : cap_q0_reg;
    end

    // Input is held off until a config change has passed through the stages above.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (cfg_wr) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Sample path: input register -> stepping logic -> result register.
    // ------------------------------------------------------------------
    sample_t          in_reg;
    logic             in_valid_reg;
    result_t          out_reg;
    logic             out_valid_reg;
    logic [FreqW-1:0] last_req_reg;
    logic             advance;
    logic             s_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = (settle_reg == 2'd0) && (!in_valid_reg || advance);
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg.load_pct     <= s_tdata[6:0];
            in_reg.current_freq <= s_tdata[28:7];
            in_reg.screen_on    <= s_tdata[29];
        end
    end

    // Stepping logic. A stale request outside [fmin, fmax] is reloaded from the
    // running frequency before stepping.
    logic             awake, go_up, go_down;
    logic [FreqW-1:0] base;
    logic [SumW-1:0]  up_sum, dn_step, dn_val, cap_lim;
    logic [FreqW-1:0] up_val;
    result_t          res_next;

    always_comb begin
        awake   = in_reg.screen_on;
        go_up   = awake && (in_reg.load_pct > up_th_reg);
        go_down = !awake || (in_reg.load_pct < dn_th_reg);
        base    = ((last_req_reg > fmax_reg) || (last_req_reg < fmin_reg))
                  ? in_reg.current_freq : last_req_reg;

        // Step up saturates at fmax.
        up_sum = SumW'(base) + SumW'(step_reg);
        up_val = (up_sum > SumW'(fmax_reg)) ? fmax_reg : up_sum[FreqW-1:0];

        // Step down: two steps while asleep; a step that swallows the request
        // drops it to fmin. Asleep, the cap (never below fmin) applies too.
        dn_step = awake ? SumW'(step_reg) : {step_reg, 1'b0};
        dn_val  = (SumW'(base) > dn_step) ? SumW'(base) - dn_step : SumW'(fmin_reg);
        cap_lim = (SumW'(cap_reg) < SumW'(fmin_reg)) ? SumW'(fmin_reg) : SumW'(cap_reg);
        if (!awake && (dn_val > cap_lim)) begin
            dn_val = cap_lim;
        end

        res_next = '0;
        if (go_up) begin
            res_next.issue       = 1'b1;
            res_next.target_freq = up_val;
            res_next.round_mode  = 1'b0;
        end else if (go_down) begin
            res_next.issue       = 1'b1;
            res_next.target_freq = dn_val[FreqW-1:0];
            res_next.round_mode  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_req_reg  <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                if (res_next.issue) begin
                    last_req_reg <= res_next.target_freq;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.round_mode, out_reg.target_freq, out_reg.issue};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_settle_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (settle_reg != 2'd0) |-> !s_tready)
        else $error("sample taken while derived limits were settling");

    a_cfg_holds_off: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_tready)
        else $error("input not held off after a configuration write");

    a_idle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[23:1] == 23'd0))
        else $error("result without issue carries a nonzero payload");

    a_request_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_next.issue) |=> (last_req_reg == out_reg.target_freq))
        else $error("last request does not follow the issued target");

endmodule

// File: tb/sv/screen_aware_freq_stepper_core_tb.sv
// Self-checking testbench for the screen-aware frequency stepper core.
module screen_aware_freq_stepper_core_tb;
    import safs_pkg::*;

    // Indexes past the last register. Writes to them must leave every register unchanged.
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int SLEEP_STEP_MUL  = 2;
    localparam logic [FreqW-1:0] FREQ_ALL_ONES = {FreqW{1'b1}};

    // All block inputs are at known values from time zero.
    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [31:0]      s_tdata  = '0;
    logic             m_tready = 1'b0;
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [AddrW-1:0] paddr    = '0;
    logic [DataW-1:0] pwdata   = '0;

    logic             s_tready;
    logic             m_tvalid;
    logic [23:0]      m_tdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    // Local copy of the register file and of the stored request. The stored request is
    // advanced only by the frequency predictor below.
    logic [PctW-1:0]  up_thr   = UP_THRESHOLD_RST;
    logic [PctW-1:0]  down_thr = DOWN_THRESHOLD_RST;
    logic [PctW-1:0]  step_pct = STEP_PERCENT_RST;
    logic [PctW-1:0]  cap_pct  = SLEEP_CAP_RST;
    logic [FreqW-1:0] fmax     = FREQ_MAX_RST;
    logic [FreqW-1:0] fmin     = FREQ_MIN_RST;
    logic [FreqW-1:0] last_req = '0;

    sample_t sample_pending[$];    // samples waiting for the driver
    result_t target_expected[$];   // predicted results, oldest first

    int  sender_idle_pct    = 0;
    int  receiver_stall_pct = 0;
    int  mismatches         = 0;
    logic sample_taken      = 1'b0;

    screen_aware_freq_stepper_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // load_pct[6:0], current_freq[28:7], screen_on[29], zero[31:30]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // issue[0], target_freq[22:1], round_mode[23]
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    // Predicts the result of one sample and advances the stored request. The step and the
    // sleep cap are percentages of freq_max, truncated; a percent above 100 is used as is.
    function automatic result_t next_target(sample_t smp);
        logic [63:0] step;
        logic [63:0] req;
        logic [63:0] cap;
        result_t     res;
        step = (64'(step_pct) * 64'(fmax)) / 64'(PCT_DIV);
        req  = 64'(last_req);
        res  = '0;
        if (smp.screen_on && smp.load_pct > up_thr) begin
            // Step up: reload from the running frequency when the stored request is
            // outside the window, then saturate at freq_max.
            if (req > fmax || req < fmin) begin
                req = 64'(smp.current_freq);
            end
            req = req + step;
            if (req > fmax) begin
                req = 64'(fmax);
            end
            last_req       = req[FreqW-1:0];
            res.issue      = 1'b1;
            res.target_freq = req[FreqW-1:0];
            res.round_mode = 1'b0;
        end else if (!smp.screen_on || smp.load_pct < down_thr) begin
            // Step down, by a double step while the screen is off. A step that is not
            // smaller than the request drops it to freq_min.
            if (req > fmax || req < fmin) begin
                req = 64'(smp.current_freq);
            end
            if (!smp.screen_on) begin
                step = step * SLEEP_STEP_MUL;
            end
            if (req > step) begin
                req = req - step;
            end else begin
                req = 64'(fmin);
            end
            if (!smp.screen_on) begin
                // Sleep ceiling, never below freq_min.
                cap = (64'(cap_pct) * 64'(fmax)) / 64'(PCT_DIV);
                if (cap < fmin) begin
                    cap = 64'(fmin);
                end
                if (req > cap) begin
                    req = cap;
                end
            end
            last_req       = req[FreqW-1:0];
            res.issue      = 1'b1;
            res.target_freq = req[FreqW-1:0];
            res.round_mode = 1'b1;
        end
        // With neither branch taken the result is all zeros and the request is kept.
        return res;
    endfunction

    // Sample driver. A new transfer is offered only once the previous one has completed,
    // so s_tvalid is never dropped while a sample is on the bus.
    always @(negedge aclk) begin : drive_samples
        sample_t smp;
        if (aresetn && (!s_tvalid || sample_taken)) begin
            if (sample_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                smp = sample_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, smp.screen_on, smp.current_freq, smp.load_pct};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Monitor. Every accepted sample produces exactly one expected result; every result
    // transfer is checked field by field against the oldest prediction.
    always @(posedge aclk) begin : watch_streams
        sample_t smp;
        result_t want;
        sample_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                smp.load_pct     = s_tdata[6:0];
                smp.current_freq = s_tdata[28:7];
                smp.screen_on    = s_tdata[29];
                target_expected.push_back(next_target(smp));
            end
            if (m_tvalid && m_tready) begin
                if (target_expected.size() == 0) begin
                    $error("unexpected result transfer, m_tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    want = target_expected.pop_front();
                    if (m_tdata[0] !== want.issue) begin
                        $error("issue: expected %0d, got %0d", want.issue, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[22:1] !== want.target_freq) begin
                        $error("target_freq: expected %0d, got %0d",
                               want.target_freq, m_tdata[22:1]);
                        mismatches++;
                    end
                    if (m_tdata[23] !== want.round_mode) begin
                        $error("round_mode: expected %0d, got %0d",
                               want.round_mode, m_tdata[23]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // One register write: setup cycle, then access cycle until pready. The local register
    // copy follows the write at the edge where it takes effect; only the field bits count.
    task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_UP_THRESHOLD:   up_thr   = value[PctW-1:0];
            REG_DOWN_THRESHOLD: down_thr = value[PctW-1:0];
            REG_STEP_PERCENT:   step_pct = value[PctW-1:0];
            REG_SLEEP_CAP:      cap_pct  = value[PctW-1:0];
            REG_FREQ_MAX:       fmax     = value[FreqW-1:0];
            REG_FREQ_MIN:       fmin     = value[FreqW-1:0];
            default: ;  // index out of range, the write is dropped
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic add_sample(input int load, input logic [FreqW-1:0] freq, input bit on);
        sample_t smp;
        smp.load_pct     = load[PctW-1:0];
        smp.current_freq = freq;
        smp.screen_on    = on;
        sample_pending.push_back(smp);
    endtask

    // Random sample biased toward the thresholds and the window edges, so that both
    // step directions, the no-request band, reloads and saturation all show up.
    task automatic add_random_sample();
        int load;
        logic [FreqW-1:0] freq;
        case ($urandom_range(9))
            6:       load = $urandom_range(127, 101);
            7:       load = int'(up_thr) + $urandom_range(1);
            8:       load = int'(down_thr) - $urandom_range(1);
            9:       load = $urandom_range(1) ? 100 : 0;
            default: load = $urandom_range(100);
        endcase
        if (load < 0) begin
            load = 0;
        end
        case ($urandom_range(7))
            4:       freq = fmin;
            5:       freq = fmax;
            6:       freq = '0;
            7:       freq = FREQ_ALL_ONES;
            default: freq = FreqW'($urandom);
        endcase
        add_sample(load, freq, $urandom_range(3) != 0);
    endtask

    // Settings for each phase. Phase 0 keeps the reset values; the next phases hit the
    // extremes, including an empty window and a zero freq_max; the rest are random and
    // carry junk in the unused upper bits of pwdata on most writes.
    task automatic program_phase(input int phase);
        logic [FreqW-1:0] top;
        case (phase)
            0: ;
            1: begin
                write_reg(REG_UP_THRESHOLD, 0);
                write_reg(REG_DOWN_THRESHOLD, 127);
                write_reg(REG_STEP_PERCENT, 127);
                write_reg(REG_SLEEP_CAP, 127);
                write_reg(REG_FREQ_MAX, DataW'(FREQ_ALL_ONES));
                write_reg(REG_FREQ_MIN, 0);
                write_reg(REG_SPARE_6, $urandom);
                write_reg(REG_SPARE_7, $urandom);
            end
            2: begin
                write_reg(REG_UP_THRESHOLD, 127);
                write_reg(REG_DOWN_THRESHOLD, 1);
                write_reg(REG_STEP_PERCENT, 1);
                write_reg(REG_SLEEP_CAP, 1);
                write_reg(REG_FREQ_MAX, 1000);
                write_reg(REG_FREQ_MIN, 900);
            end
            3: begin
                // freq_min above freq_max: every request is reloaded.
                write_reg(REG_UP_THRESHOLD, 50);
                write_reg(REG_DOWN_THRESHOLD, 50);
                write_reg(REG_STEP_PERCENT, 50);
                write_reg(REG_SLEEP_CAP, 100);
                write_reg(REG_FREQ_MAX, 100);
                write_reg(REG_FREQ_MIN, DataW'(FREQ_ALL_ONES));
            end
            4: begin
                write_reg(REG_UP_THRESHOLD, 100);
                write_reg(REG_DOWN_THRESHOLD, 0);
                write_reg(REG_STEP_PERCENT, 100);
                write_reg(REG_SLEEP_CAP, 0);
                write_reg(REG_FREQ_MAX, 0);
                write_reg(REG_FREQ_MIN, 0);
            end
            default: begin
                top = FreqW'($urandom);
                write_reg(REG_UP_THRESHOLD, ($urandom << PctW) | $urandom_range(100));
                write_reg(REG_DOWN_THRESHOLD, ($urandom << PctW) | $urandom_range(100, 1));
                write_reg(REG_STEP_PERCENT, ($urandom << PctW) | $urandom_range(127, 1));
                write_reg(REG_SLEEP_CAP, ($urandom << PctW) | $urandom_range(127, 1));
                write_reg(REG_FREQ_MAX, ($urandom << FreqW) | DataW'(top));
                write_reg(REG_FREQ_MIN, $urandom_range(3) != 0 ? $urandom_range(top) : $urandom);
            end
        endcase
    endtask

    // Registers may only change with nothing in flight.
    task automatic wait_idle();
        while (sample_pending.size() > 0 || s_tvalid || target_expected.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            program_phase(phase);
            // Rotate through no idling, a slow sender, a slow receiver and both.
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
                default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
            endcase
            if (phase == 0) begin
                // Directed samples on the reset settings: the stored request starts at
                // zero, then both threshold edges, sleep with the cap, and saturation.
                add_sample(0, 0, 1'b1);
                add_sample(100, FREQ_ALL_ONES, 1'b1);
                add_sample(127, 0, 1'b1);
                add_sample(65, FREQ_ALL_ONES, 1'b1);
                add_sample(35, 0, 1'b1);
                add_sample(34, 12345, 1'b1);
                add_sample(66, 0, 1'b1);
                add_sample(100, 1000, 1'b0);
                add_sample(0, 0, 1'b0);
                repeat (12) add_sample(100, FREQ_ALL_ONES, 1'b1);
                add_sample(1, FREQ_ALL_ONES, 1'b1);
                add_sample(127, FREQ_ALL_ONES, 1'b0);
            end
            repeat (ITEMS_PER_PHASE) add_random_sample();
        end

        wait_idle();
        // A few more cycles to catch a stray result after the last expected one.
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[screen_aware_freq_stepper_core] OK");
        end else begin
            $display("[screen_aware_freq_stepper_core] ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("[screen_aware_freq_stepper_core] ERROR");
        $finish;
    end

endmodule
